[rtl/core/fan_speed_timer_controller_defines.svh]
// Assertion macros shared by the fan speed timer controller RTL.
`ifndef FAN_SPEED_TIMER_CONTROLLER_DEFINES_SVH
`define FAN_SPEED_TIMER_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF
// Concurrent property check, clocked and disabled during reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[rtl/core/fst_pkg.sv]
package fst_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_COUNTDOWN_START  = 2'd0;
    localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd1;
    localparam logic [1:0] REG_DUTY_LOW_SPEED   = 2'd2;
    localparam logic [1:0] REG_DUTY_HIGH_SPEED  = 2'd3;

    localparam logic [7:0] COUNTDOWN_START_RST  = 8'd10;
    localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd250;
    localparam logic [7:0] DUTY_LOW_SPEED_RST   = 8'd127;
    localparam logic [7:0] DUTY_HIGH_SPEED_RST  = 8'd229;

    // button bit positions (active low)
    localparam int unsigned BTN_TIMER = 0;
    localparam int unsigned BTN_HIGH  = 1;
    localparam int unsigned BTN_LOW   = 2;
    localparam int unsigned BTN_STOP  = 3;

    // display digit positions
    localparam logic [1:0] DIG_THOUSANDS = 2'd0;
    localparam logic [1:0] DIG_HUNDREDS  = 2'd1;
    localparam logic [1:0] DIG_TENS      = 2'd2;

    localparam logic [7:0] SEG_ZERO   = 8'h3F;
    localparam logic [7:0] SEG_ONE    = 8'h06;
    localparam logic [7:0] SEG_TWO    = 8'h5B;
    localparam logic [3:0] SELECT_OFF = 4'hF;

    typedef enum logic [4:0] {
        MODE_NONE    = 5'b00001,
        MODE_EXPIRED = 5'b00010,
        MODE_HIGH    = 5'b00100,
        MODE_LOW     = 5'b01000,
        MODE_STOPPED = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [7:0] countdown_start;
        logic [7:0] ticks_per_second;
        logic [7:0] duty_low_speed;
        logic [7:0] duty_high_speed;
    } cfg_t;

    typedef struct packed {
        logic [3:0] buttons_n;
        logic       timer_tick;
    } item_t;

    typedef struct packed {
        logic [7:0] pwm_duty;
        logic [7:0] speed_segments;
        logic [7:0] led_bar;
        logic [3:0] digit_select_n;
        logic [7:0] digit_segments;
        logic       timer_active;
    } result_t;

    typedef struct packed {
        logic [7:0] cd_sub;
        logic [7:0] cd_sec;
        logic [7:0] free_sub;
        logic [7:0] free_sec;
        logic       display_on;
        mode_t      mode;
        logic [1:0] digit_pos;
        logic [7:0] duty;
        logic [7:0] speed_seg;
        logic [7:0] led;
        logic [7:0] digit_seg;
        logic [3:0] select_n;
    } state_t;

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        case (d)
            4'd0:    seg_of = 8'h3F;
            4'd1:    seg_of = 8'h06;
            4'd2:    seg_of = 8'h5B;
            4'd3:    seg_of = 8'h4F;
            4'd4:    seg_of = 8'h66;
            4'd5:    seg_of = 8'h6D;
            4'd6:    seg_of = 8'h7D;
            4'd7:    seg_of = 8'h27;
            4'd8:    seg_of = 8'h7F;
            4'd9:    seg_of = 8'h67;
            default: seg_of = 8'h3F;
        endcase
    endfunction

    // thermometer pattern with idx+1 lit LEDs
    function automatic logic [7:0] bar_of(input logic [2:0] idx);
        bar_of = 8'hFF >> (3'd7 - idx);
    endfunction

    function automatic logic [3:0] sel_of(input logic [1:0] pos);
        sel_of = ~(4'b0001 << pos);
    endfunction

    // decimal digit of an 8-bit value; tens found by multiply with 205/2048
    function automatic logic [3:0] digit_of(input logic [7:0] v, input logic [1:0] pos);
        logic [1:0]  hund;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [3:0]  ones;
        hund     = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        rem      = 7'(v - 8'(8'(hund) * 8'd100));
        prod     = 15'(rem) * 15'd205;
        tens     = 4'(prod >> 11);
        tens_x10 = 7'(tens) * 7'd10;
        ones     = 4'(rem - tens_x10);
        case (pos)
            DIG_THOUSANDS: digit_of = 4'd0;
            DIG_HUNDREDS:  digit_of = {2'b00, hund};
            DIG_TENS:      digit_of = tens;
            default:       digit_of = ones;
        endcase
    endfunction

endpackage

[rtl/core/fan_speed_timer_controller.sv]
// Channel   Dir  Fields (tdata, lowest bit first)
// s_axis    in   buttons_n[3:0], timer_tick[4], zero pad [7:5]
// m_axis    out  pwm_duty[7:0], speed_segments[15:8], led_bar[23:16],
//                digit_select_n[27:24], digit_segments[35:28], timer_active[36], pad
// cfg       in   cfg_wr_en, cfg_addr (register index), cfg_wr_data
//
// One word per cycle sustained while m_tready stays high; each word passes the input
// register and then the result register, and m_tvalid rises once its result is written.
// The pass is an input register, one level of step logic, then the result register.
// aresetn is synchronous and active low; it clears the loop state and both stages.
// A stalled m_ side holds its word; the input stage still takes a word if the
// result register empties in the same cycle.
`include "fan_speed_timer_controller_defines.svh"

module fan_speed_timer_controller
    import fst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // buttons_n[3:0], timer_tick[4]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pwm_duty, speed_segments, led_bar, digit_select_n,
                                   // digit_segments, timer_active
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wr_data
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    cfg_t    cfg_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= '{buttons_n: s_tdata[3:0], timer_tick: s_tdata[4]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{countdown_start:  COUNTDOWN_START_RST,
                         ticks_per_second: TICKS_PER_SECOND_RST,
                         duty_low_speed:   DUTY_LOW_SPEED_RST,
                         duty_high_speed:  DUTY_HIGH_SPEED_RST};
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_COUNTDOWN_START:  cfg_reg.countdown_start  <= cfg_wr_data;
                REG_TICKS_PER_SECOND: cfg_reg.ticks_per_second <= cfg_wr_data;
                REG_DUTY_LOW_SPEED:   cfg_reg.duty_low_speed   <= cfg_wr_data;
                REG_DUTY_HIGH_SPEED:  cfg_reg.duty_high_speed  <= cfg_wr_data;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    fst_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{cd_sub:     8'd0,
                           cd_sec:     COUNTDOWN_START_RST,
                           free_sub:   8'd0,
                           free_sec:   8'd0,
                           display_on: 1'b0,
                           mode:       MODE_NONE,
                           digit_pos:  2'd0,
                           duty:       8'd0,
                           speed_seg:  8'd0,
                           led:        8'd0,
                           digit_seg:  8'd0,
                           select_n:   SELECT_OFF};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_res_reg.timer_active,
                       out_res_reg.digit_segments,
                       out_res_reg.digit_select_n,
                       out_res_reg.led_bar,
                       out_res_reg.speed_segments,
                       out_res_reg.pwm_duty};

    `ASSERT_PROP(a_in_room, aclk, aresetn, !in_valid_reg |-> s_tready,
                 "empty input stage refused a word")
    `ASSERT_PROP(a_sel_onehot, aclk, aresetn,
                 m_tvalid |-> ($onehot(~m_tdata[27:24]) || m_tdata[27:24] == SELECT_OFF),
                 "digit select not one-hot or off")
    `ASSERT_PROP(a_cd_hold, aclk, aresetn,
                 advance && !in_item_reg.timer_tick && in_item_reg.buttons_n[BTN_TIMER]
                 |=> $stable(state_reg.cd_sec),
                 "countdown moved without tick or timer button")
    `ASSERT_PROP(a_stop_duty, aclk, aresetn,
                 advance && !in_item_reg.buttons_n[BTN_STOP] |=> m_tvalid && m_tdata[7:0] == 8'd0,
                 "stop button left duty non-zero")

endmodule

[rtl/core/fst_step.sv]
module fst_step
    import fst_pkg::*;
(
    input  state_t  st,
    input  cfg_t    cfg,
    input  item_t   item,
    output state_t  st_next,
    output result_t res
);

    logic [7:0] cd_sub_inc;
    logic [7:0] free_sub_inc;

    assign cd_sub_inc   = st.cd_sub + 8'd1;
    assign free_sub_inc = st.free_sub + 8'd1;

    always_comb begin
        st_next = st;

        // tick handling first
        if (item.timer_tick) begin
            if (cd_sub_inc == cfg.ticks_per_second) begin
                st_next.cd_sub = 8'd0;
                st_next.cd_sec = st.cd_sec - 8'd1;
            end else begin
                st_next.cd_sub = cd_sub_inc;
            end
            if (free_sub_inc == cfg.ticks_per_second) begin
                st_next.free_sub = 8'd0;
                st_next.free_sec = st.free_sec + 8'd1;
            end else begin
                st_next.free_sub = free_sub_inc;
            end
        end

        // buttons in priority order
        if (!item.buttons_n[BTN_STOP]) begin
            st_next.speed_seg  = SEG_ZERO;
            st_next.duty       = 8'd0;
            st_next.display_on = 1'b0;
            st_next.led        = 8'd0;
            st_next.mode       = MODE_STOPPED;
        end else if (!item.buttons_n[BTN_LOW]) begin
            st_next.speed_seg  = SEG_ONE;
            st_next.duty       = cfg.duty_low_speed;
            st_next.display_on = 1'b0;
            st_next.free_sec   = 8'd0;
            st_next.mode       = MODE_LOW;
        end else if (!item.buttons_n[BTN_HIGH]) begin
            st_next.speed_seg  = SEG_TWO;
            st_next.duty       = cfg.duty_high_speed;
            st_next.display_on = 1'b0;
            st_next.free_sec   = 8'd0;
            st_next.mode       = MODE_HIGH;
        end else if (!item.buttons_n[BTN_TIMER]) begin
            st_next.display_on = 1'b1;
            st_next.cd_sec     = cfg.countdown_start;
            st_next.cd_sub     = 8'd0;
        end

        // drive one countdown digit; stop the fan at zero
        if (st_next.display_on) begin
            st_next.select_n  = sel_of(st.digit_pos);
            st_next.digit_seg = seg_of(digit_of(st_next.cd_sec, st.digit_pos));
            st_next.digit_pos = st.digit_pos + 2'd1;
            if (st_next.cd_sec == 8'd0) begin
                st_next.display_on = 1'b0;
                st_next.speed_seg  = SEG_ZERO;
                st_next.duty       = 8'd0;
                st_next.mode       = MODE_EXPIRED;
                st_next.led        = 8'd0;
            end
        end else begin
            st_next.select_n = SELECT_OFF;
        end

        case (st_next.mode)
            MODE_LOW:  st_next.led = bar_of(st_next.free_sec[2:0]);
            MODE_HIGH: st_next.led = bar_of({st_next.free_sec[1:0], 1'b1});
            default:   st_next.led = st_next.led;
        endcase

        res.pwm_duty       = st_next.duty;
        res.speed_segments = st_next.speed_seg;
        res.led_bar        = st_next.led;
        res.digit_select_n = st_next.select_n;
        res.digit_segments = st_next.digit_seg;
        res.timer_active   = st_next.display_on;
    end

endmodule

[tb/fan_speed_timer_controller_checker.sv]
`timescale 1ns / 1ps

module fan_speed_timer_controller_checker
    import fst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // buttons_n[3:0], timer_tick[4]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // pwm_duty, speed_segments, led_bar, digit_select_n,
                                   // digit_segments, timer_active
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wr_data,
    output int          fail_count,
    output int          pending
);

    // register copies
    logic [7:0] start_secs;
    logic [7:0] ticks_per_sec;
    logic [7:0] duty_low;
    logic [7:0] duty_high;

    // loop state
    logic [7:0] cd_sub;
    logic [7:0] cd_sec;
    logic [7:0] free_sub;
    logic [7:0] free_sec;
    logic       disp_on;
    mode_t      fan_mode;
    logic [1:0] digit_pos;
    logic [7:0] duty;
    logic [7:0] speed_seg;
    logic [7:0] led;
    logic [7:0] digit_seg;
    logic [3:0] select_n;

    result_t pass_results[$];

    initial fail_count = 0;
    initial pending = 0;

    function automatic logic [7:0] seven_seg(input logic [7:0] d);
        case (d)
            8'd0:    return 8'h3F;
            8'd1:    return 8'h06;
            8'd2:    return 8'h5B;
            8'd3:    return 8'h4F;
            8'd4:    return 8'h66;
            8'd5:    return 8'h6D;
            8'd6:    return 8'h7D;
            8'd7:    return 8'h27;
            8'd8:    return 8'h7F;
            default: return 8'h67;
        endcase
    endfunction

    // n+1 lit LEDs from the bottom
    function automatic logic [7:0] led_thermo(input logic [2:0] n);
        logic [8:0] v;
        v = (9'd2 << n) - 9'd1;
        return v[7:0];
    endfunction

    task automatic run_pass(input logic [3:0] btn, input logic tick, output result_t r);
        logic [1:0] p;
        logic [7:0] d;
        if (tick) begin
            cd_sub   = cd_sub + 8'd1;
            free_sub = free_sub + 8'd1;
            if (cd_sub == ticks_per_sec) begin
                cd_sub = 8'd0;
                cd_sec = cd_sec - 8'd1;
            end
            if (free_sub == ticks_per_sec) begin
                free_sub = 8'd0;
                free_sec = free_sec + 8'd1;
            end
        end

        // highest-priority pressed button wins
        if (!btn[BTN_STOP]) begin
            speed_seg = SEG_ZERO;
            duty      = 8'd0;
            disp_on   = 1'b0;
            led       = 8'd0;
            fan_mode  = MODE_STOPPED;
        end else if (!btn[BTN_LOW]) begin
            speed_seg = SEG_ONE;
            duty      = duty_low;
            disp_on   = 1'b0;
            free_sec  = 8'd0;
            fan_mode  = MODE_LOW;
        end else if (!btn[BTN_HIGH]) begin
            speed_seg = SEG_TWO;
            duty      = duty_high;
            disp_on   = 1'b0;
            free_sec  = 8'd0;
            fan_mode  = MODE_HIGH;
        end else if (!btn[BTN_TIMER]) begin
            disp_on = 1'b1;
            cd_sec  = start_secs;
            cd_sub  = 8'd0;
        end

        if (disp_on) begin
            p        = digit_pos;
            select_n = ~(4'b0001 << p);
            case (p)
                DIG_THOUSANDS: d = 8'd0;
                DIG_HUNDREDS:  d = cd_sec / 8'd100;
                DIG_TENS:      d = (cd_sec / 8'd10) % 8'd10;
                default:       d = cd_sec % 8'd10;
            endcase
            digit_seg = seven_seg(d);
            digit_pos = p + 2'd1;
            // the digit just driven stays lit for this pass only
            if (cd_sec == 8'd0) begin
                disp_on   = 1'b0;
                speed_seg = SEG_ZERO;
                duty      = 8'd0;
                fan_mode  = MODE_EXPIRED;
                led       = 8'd0;
            end
        end else begin
            select_n = SELECT_OFF;
        end

        if (fan_mode == MODE_LOW)
            led = led_thermo(free_sec[2:0]);
        else if (fan_mode == MODE_HIGH)
            led = led_thermo({free_sec[1:0], 1'b1});

        r.pwm_duty       = duty;
        r.speed_segments = speed_seg;
        r.led_bar        = led;
        r.digit_select_n = select_n;
        r.digit_segments = digit_seg;
        r.timer_active   = disp_on;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            start_secs    = COUNTDOWN_START_RST;
            ticks_per_sec = TICKS_PER_SECOND_RST;
            duty_low      = DUTY_LOW_SPEED_RST;
            duty_high     = DUTY_HIGH_SPEED_RST;
            cd_sub        = 8'd0;
            cd_sec        = COUNTDOWN_START_RST;
            free_sub      = 8'd0;
            free_sec      = 8'd0;
            disp_on       = 1'b0;
            fan_mode      = MODE_NONE;
            digit_pos     = 2'd0;
            duty          = 8'd0;
            speed_seg     = 8'd0;
            led           = 8'd0;
            digit_seg     = 8'd0;
            select_n      = SELECT_OFF;
            pass_results.delete();
            pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_COUNTDOWN_START:  start_secs    = cfg_wr_data;
                    REG_TICKS_PER_SECOND: ticks_per_sec = cfg_wr_data;
                    REG_DUTY_LOW_SPEED:   duty_low      = cfg_wr_data;
                    REG_DUTY_HIGH_SPEED:  duty_high     = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                run_pass(s_tdata[3:0], s_tdata[4], want);
                pass_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.pwm_duty       = m_tdata[7:0];
                got.speed_segments = m_tdata[15:8];
                got.led_bar        = m_tdata[23:16];
                got.digit_select_n = m_tdata[27:24];
                got.digit_segments = m_tdata[35:28];
                got.timer_active   = m_tdata[36];
                if (pass_results.size() == 0) begin
                    report_mismatch($sformatf("result word %h with none expected", m_tdata));
                end else begin
                    want = pass_results.pop_front();
                    check_field("pwm_duty", got.pwm_duty, want.pwm_duty);
                    check_field("speed_segments", got.speed_segments, want.speed_segments);
                    check_field("led_bar", got.led_bar, want.led_bar);
                    check_field("digit_select_n", {4'd0, got.digit_select_n},
                                {4'd0, want.digit_select_n});
                    check_field("digit_segments", got.digit_segments, want.digit_segments);
                    check_field("timer_active", {7'd0, got.timer_active},
                                {7'd0, want.timer_active});
                end
            end
            pending <= pass_results.size();
        end
    end

endmodule

[tb/tb_fan_speed_timer_controller.sv]
`timescale 1ns / 1ps

module tb_fan_speed_timer_controller;
    import fst_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 72;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h0F;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_addr    = REG_COUNTDOWN_START;
    logic [7:0]  cfg_wr_data = 8'd0;

    int fail_count;
    int pending;
    int cycles = 0;
    bit steady = 1'b0;   // no idling on either side while set

    always #5 aclk = ~aclk;

    fan_speed_timer_controller dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    fan_speed_timer_controller_checker fan_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[fan_speed_timer_controller] ERROR");
            $finish;
        end
    end

    task automatic send_pass(input logic [3:0] buttons_n, input logic tick);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, tick, buttons_n};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold the input until every result is out, then let the pipeline empty
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_pass;
        int r;
        logic [3:0] buttons_n;
        r = $urandom_range(0, 99);
        if (r < 72)      buttons_n = 4'hF;
        else if (r < 78) buttons_n = 4'hE;   // timer
        else if (r < 84) buttons_n = 4'hB;   // low
        else if (r < 90) buttons_n = 4'hD;   // high
        else if (r < 95) buttons_n = 4'h7;   // stop
        else             buttons_n = 4'($urandom_range(0, 15));
        send_pass(buttons_n, $urandom_range(0, 2) != 0);
    endtask

    always begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: lone buttons, combinations, digit scan
        send_pass(4'hF, 1'b0);
        send_pass(4'hF, 1'b1);
        send_pass(4'hE, 1'b0);
        send_pass(4'hF, 1'b1);
        send_pass(4'hF, 1'b0);
        send_pass(4'hF, 1'b1);
        send_pass(4'hF, 1'b0);
        send_pass(4'hD, 1'b1);
        send_pass(4'hB, 1'b0);
        send_pass(4'h7, 1'b1);
        send_pass(4'h0, 1'b0);
        send_pass(4'hA, 1'b1);
        send_pass(4'hC, 1'b0);
        send_pass(4'h6, 1'b1);
        send_pass(4'hE, 1'b1);
        drain();

        // timer from zero expires at once; one tick per second moves the bar
        write_reg(REG_COUNTDOWN_START, 8'd0);
        write_reg(REG_TICKS_PER_SECOND, 8'd1);
        write_reg(REG_DUTY_LOW_SPEED, 8'd255);
        write_reg(REG_DUTY_HIGH_SPEED, 8'd0);
        send_pass(4'hE, 1'b1);
        send_pass(4'hF, 1'b1);
        send_pass(4'hB, 1'b1);
        send_pass(4'hF, 1'b1);
        send_pass(4'hF, 1'b1);
        send_pass(4'hD, 1'b1);
        send_pass(4'hF, 1'b1);
        send_pass(4'hF, 1'b0);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            steady = (phase % 3 == 2);
            case (phase)
                0: begin
                    write_reg(REG_COUNTDOWN_START, 8'd255);
                    write_reg(REG_TICKS_PER_SECOND, 8'd255);
                    write_reg(REG_DUTY_LOW_SPEED, 8'd0);
                    write_reg(REG_DUTY_HIGH_SPEED, 8'd255);
                end
                1: begin
                    write_reg(REG_COUNTDOWN_START, 8'd3);
                    write_reg(REG_TICKS_PER_SECOND, 8'd2);
                    write_reg(REG_DUTY_LOW_SPEED, 8'($urandom));
                    write_reg(REG_DUTY_HIGH_SPEED, 8'($urandom));
                end
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        write_reg(REG_COUNTDOWN_START, 8'($urandom));
                    else
                        write_reg(REG_COUNTDOWN_START, 8'($urandom_range(0, 20)));
                    write_reg(REG_TICKS_PER_SECOND, 8'($urandom_range(1, 6)));
                    write_reg(REG_DUTY_LOW_SPEED, 8'($urandom));
                    write_reg(REG_DUTY_HIGH_SPEED, 8'($urandom));
                end
            endcase
            repeat (PHASE_ITEMS) send_random_pass();
            drain();
        end

        steady = 1'b0;
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("[fan_speed_timer_controller] OK");
        else
            $display("[fan_speed_timer_controller] ERROR");
        $finish;
    end

endmodule
